>>> rtl/priority_task_table_top_assert.svh
// ----------------------------------------------------------------------------
// Priority task table assertion macros
// Concurrent check macros, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_TASK_TABLE_TOP_ASSERT_SVH
`define PRIORITY_TASK_TABLE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define PTT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("priority_task_table_top: same-cycle check failed");
// Next-cycle implication.
`define PTT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("priority_task_table_top: next-cycle check failed");
`else
`define PTT_ASSERT_IMPL(lbl, ante, cons)
`define PTT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// Priority task table package
// Sizes, codes and shared types of the priority task table.
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

	localparam int CAPACITY  = 16;
	localparam int TAG_BITS  = 16;
	localparam int PRIO_BITS = 16;
	localparam int IDX_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef enum logic {
		FUNC_INSERT = 1'b0,
		FUNC_REMOVE = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_DUP     = 2'd1,
		ST_MISSING = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_SCAN = 2'd1,
		S_FIN  = 2'd2
	} state_t;

	// compare unit result
	typedef struct packed {
		logic eq;   // candidate equals key
		logic lt;   // candidate below current best (signed)
	} cmp_res_t;

endpackage

`default_nettype wire

>>> rtl/ptt_cmp_unit.sv
// ----------------------------------------------------------------------------
// Priority task table compare unit
// Shared signed compare: match against the key, order against the best.
// ----------------------------------------------------------------------------
`default_nettype none

module ptt_cmp_unit
	import ptt_pkg::*;
(
	input  wire logic signed [PRIO_BITS-1:0] cand_prio,
	input  wire logic signed [PRIO_BITS-1:0] key_prio,
	input  wire logic signed [PRIO_BITS-1:0] best_prio,
	output cmp_res_t                         res
);

	always_comb begin
		res.eq = (cand_prio == key_prio);
		res.lt = (cand_prio < best_prio);
	end

endmodule

`default_nettype wire

>>> rtl/priority_task_table_top.sv
// ----------------------------------------------------------------------------
// Priority task table
// Bounded table of uniquely prioritized tasks with a lowest-priority readout.
// ----------------------------------------------------------------------------
//
//   Channel  Handshake             Payload
//   -------  --------------------  --------------------------------------------
//   in       in_valid / in_stall   func, priority_req, task_tag
//   out      out_valid / out_stall status, table_empty, lowest_priority,
//                                  lowest_tag
//
// Each request runs a scan through the single compare unit (one table entry
// per cycle) and then a finish state that applies the update and loads the
// result register. A new request is taken in the finish state, so the scan
// of the next request follows straight on from the finish of the last one.
// A stalled result holds the finish cycle until the result register frees up.
// Reset clears the valid bits, the sequencer and the result valid; priority
// and tag storage is never read before it is written.
//
// The scan tracks the key match, the first free slot and the minimum over the
// valid entries. On remove the matching entry is left out of the minimum; on
// a successful insert the new key is folded in during the finish cycle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "priority_task_table_top_assert.svh"

module priority_task_table_top
	import ptt_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// request channel
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        func,
	input  wire logic signed [PRIO_BITS-1:0] priority_req,
	input  wire logic        [TAG_BITS-1:0]  task_tag,
	// result channel
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic             [1:0]           status,
	output logic                             table_empty,
	output logic signed      [PRIO_BITS-1:0] lowest_priority,
	output logic             [TAG_BITS-1:0]  lowest_tag
);

	localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(CAPACITY - 1);

	// table storage
	logic        [CAPACITY-1:0]  valid_q;
	logic signed [PRIO_BITS-1:0] prio_mem [CAPACITY];
	logic        [TAG_BITS-1:0]  tag_mem  [CAPACITY];

	// sequencer
	state_t              state_q, state_d;
	logic [IDX_BITS-1:0] idx_q;

	// captured request
	func_t                       func_q;
	logic signed [PRIO_BITS-1:0] prio_q;
	logic        [TAG_BITS-1:0]  tag_q;

	// scan results
	logic                        hit_q;
	logic        [IDX_BITS-1:0]  hit_idx_q;
	logic                        free_found_q;
	logic        [IDX_BITS-1:0]  free_idx_q;
	logic                        best_found_q;
	logic signed [PRIO_BITS-1:0] best_prio_q;
	logic        [TAG_BITS-1:0]  best_tag_q;

	// result register
	logic                        out_valid_q;
	status_t                     status_q;
	logic                        empty_q;
	logic signed [PRIO_BITS-1:0] low_prio_q;
	logic        [TAG_BITS-1:0]  low_tag_q;

	// shared compare unit
	logic signed [PRIO_BITS-1:0] cand_prio;
	logic signed [PRIO_BITS-1:0] cur_prio;
	logic        [TAG_BITS-1:0]  cur_tag;
	logic                        cur_valid;
	cmp_res_t                    cmp;

	logic    fin_go;
	logic    accept;
	logic    scan_take;
	logic    fin_wr;
	logic    fin_clr;
	status_t fin_status;
	logic    fin_found;
	logic signed [PRIO_BITS-1:0] fin_prio;
	logic        [TAG_BITS-1:0]  fin_tag;

	assign cur_prio  = prio_mem[idx_q];
	assign cur_tag   = tag_mem[idx_q];
	assign cur_valid = valid_q[idx_q];

	// scan compares the current entry; finish compares the new key
	assign cand_prio = (state_q == S_FIN) ? prio_q : cur_prio;

	ptt_cmp_unit u_cmp (
		.cand_prio (cand_prio),
		.key_prio  (prio_q),
		.best_prio (best_prio_q),
		.res       (cmp)
	);

	// removed entry stays out of the minimum
	assign scan_take = cur_valid && !((func_q == FUNC_REMOVE) && cmp.eq)
		&& (!best_found_q || cmp.lt);

	always_comb begin
		fin_go   = (state_q == S_FIN) && (!out_valid_q || !out_stall);
		in_stall = !((state_q == S_IDLE) || fin_go);
		accept   = in_valid && !in_stall;
		state_d  = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (idx_q == LAST_IDX) state_d = S_FIN;
			end
			S_FIN: begin
				if (accept) state_d = S_SCAN;
				else if (fin_go) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// finish: status, table update and final minimum
	always_comb begin
		fin_wr     = 1'b0;
		fin_clr    = 1'b0;
		fin_status = ST_DONE;
		fin_found  = best_found_q;
		fin_prio   = best_prio_q;
		fin_tag    = best_tag_q;
		if (func_q == FUNC_INSERT) begin
			if (hit_q) begin
				fin_status = ST_DUP;
			end else if (!free_found_q) begin
				fin_status = ST_FULL;
			end else begin
				fin_wr = 1'b1;
				if (!best_found_q || cmp.lt) begin
					fin_found = 1'b1;
					fin_prio  = prio_q;
					fin_tag   = tag_q;
				end
			end
		end else begin
			if (hit_q) fin_clr = 1'b1;
			else fin_status = ST_MISSING;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer index and scan flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
		end else if (accept) begin
			idx_q        <= '0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			best_found_q <= 1'b0;
		end else if (state_q == S_SCAN) begin
			idx_q <= idx_q + 1'b1;
			if (cur_valid && cmp.eq) hit_q <= 1'b1;
			if (!cur_valid && !free_found_q) free_found_q <= 1'b1;
			if (scan_take) best_found_q <= 1'b1;
		end
	end

	// scan payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func_t'(func);
			prio_q <= priority_req;
			tag_q  <= task_tag;
		end
		if (state_q == S_SCAN) begin
			if (cur_valid && cmp.eq) hit_idx_q <= idx_q;
			if (!cur_valid && !free_found_q) free_idx_q <= idx_q;
			if (scan_take) begin
				best_prio_q <= cur_prio;
				best_tag_q  <= cur_tag;
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (fin_go) begin
			if (fin_wr) valid_q[free_idx_q] <= 1'b1;
			if (fin_clr) valid_q[hit_idx_q] <= 1'b0;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (fin_go && fin_wr) begin
			prio_mem[free_idx_q] <= prio_q;
			tag_mem[free_idx_q]  <= tag_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			status_q   <= fin_status;
			empty_q    <= !fin_found;
			low_prio_q <= fin_found ? fin_prio : '0;
			low_tag_q  <= fin_found ? fin_tag : '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign table_empty     = empty_q;
	assign lowest_priority = low_prio_q;
	assign lowest_tag      = low_tag_q;

	// checks
	`PTT_ASSERT_NEXT(a_fin_result, fin_go, out_valid)
	`PTT_ASSERT_NEXT(a_accept_scan, accept, (state_q == S_SCAN) && (idx_q == '0))
	`PTT_ASSERT_IMPL(a_empty_zero, out_valid && table_empty,
		(lowest_priority == '0) && (lowest_tag == '0))
	`PTT_ASSERT_IMPL(a_full_not_empty, out_valid && (status == ST_FULL), !table_empty)

endmodule

`default_nettype wire
